// ===== hw/rtl/multiturn_joint_speed_control_unit_macros.svh =====
// Assertion macros shared by the joint speed control RTL.
`ifndef MULTITURN_JOINT_SPEED_CONTROL_UNIT_MACROS_SVH
`define MULTITURN_JOINT_SPEED_CONTROL_UNIT_MACROS_SVH

// Same-cycle implication, disabled while the synchronous reset is low.
`define MJSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("joint speed control: same-cycle check failed");

// Next-cycle implication, disabled while the synchronous reset is low.
`define MJSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("joint speed control: next-cycle check failed");

`endif

// ===== hw/rtl/mjsc_pkg.sv =====
// Package with types, widths, codes and constants of the joint speed control block.
package mjsc_pkg;

    localparam int JOINTS         = 3;
    localparam int COUNTS_PER_REV = 4095;

    localparam int JOINT_W   = 2;
    localparam int READ_W    = 12;
    localparam int TGT_W     = 28;
    localparam int POS_W     = 28;
    localparam int SPD_W     = 16;
    localparam int MAXS_W    = 15;
    localparam int REV_W     = 16;
    localparam int ERR_W     = POS_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 15;

    localparam int JIDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // Bits of an error magnitude below one revolution, and bits that hold the count itself.
    localparam int CPR_W  = $clog2(COUNTS_PER_REV);
    localparam int CPR1_W = $clog2(COUNTS_PER_REV + 1);

    // Full-precision width of revolutions times counts plus reading.
    localparam int POS_FW = (18 + CPR1_W > ERR_W) ? 18 + CPR1_W : ERR_W;

    localparam logic signed [POS_FW-1:0] CPR_POS = POS_FW'(COUNTS_PER_REV);
    localparam logic signed [POS_FW-1:0] POS_MAX_F = POS_FW'((2 ** (POS_W - 1)) - 1);
    localparam logic signed [POS_FW-1:0] POS_MIN_F = POS_FW'(-(2 ** (POS_W - 1)));

    // Division by the revolution count is a multiplication by a rounded-up reciprocal.
    localparam int PROD_W      = CPR_W + MAXS_W;
    localparam int RECIP_W     = PROD_W + 1;
    localparam int RECIP_SHIFT = PROD_W + CPR_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(COUNTS_PER_REV) - 64'd1) / 64'(COUNTS_PER_REV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    // Request codes.
    localparam logic REQ_TARGET = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 2'd2;

    localparam logic [READ_W-1:0] WRAP_THRESHOLD_RST = 12'd2000;
    localparam logic [READ_W-1:0] DEADBAND_RST       = 12'd11;
    localparam logic [MAXS_W-1:0] SPEED_LIMIT_RST    = 15'd30000;

    typedef struct packed {
        logic [READ_W-1:0] wrap_threshold;
        logic [READ_W-1:0] deadband;
        logic [MAXS_W-1:0] speed_limit;
    } t_cfg;

    typedef struct packed {
        logic                    req_type;
        logic [JOINT_W-1:0]      joint;
        logic [READ_W-1:0]       reading;
        logic signed [TGT_W-1:0] target;
    } t_req;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] position;
        logic signed [ERR_W-1:0] err;
    } t_err_item;

endpackage

// ===== hw/rtl/mjsc_req_if.sv =====
// Request channel interface: set-target and encoder sample items.
interface mjsc_req_if import mjsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [JOINT_W-1:0]      joint;
    logic [READ_W-1:0]       reading;
    logic signed [TGT_W-1:0] target;

    modport source (output valid, output req_type, output joint, output reading,
                    output target, input ready);
    modport sink   (input valid, input req_type, input joint, input reading,
                    input target, output ready);
endinterface

// ===== hw/rtl/mjsc_res_if.sv =====
// Result channel interface: position and speed command per joint sample.
interface mjsc_res_if import mjsc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [JOINT_W-1:0]      joint_out;
    logic signed [POS_W-1:0] position;
    logic signed [SPD_W-1:0] speed_cmd;

    modport source (output valid, output joint_out, output position, output speed_cmd,
                    input ready);
    modport sink   (input valid, input joint_out, input position, input speed_cmd,
                    output ready);
endinterface

// ===== hw/rtl/mjsc_joint_state.sv =====
// Per-joint state, revolution unwrap, position and position error stage.
`include "multiturn_joint_speed_control_unit_macros.svh"

module mjsc_joint_state import mjsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_req      i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_err_item o_item,
    input  logic      i_ready
);

    logic [READ_W-1:0]       r_prior  [JOINTS];
    logic                    r_primed [JOINTS];
    logic [REV_W-1:0]        r_rev    [JOINTS];
    logic signed [TGT_W-1:0] r_target [JOINTS];

    logic      r_valid;
    t_err_item r_item;

    logic                     take;
    logic                     j_ok;
    logic                     is_sample;
    logic                     produce;
    logic [JIDX_W-1:0]        idx;
    logic signed [READ_W:0]   diff;
    logic [READ_W:0]          adiff;
    logic                     wrap;
    logic [REV_W-1:0]         n_rev;
    logic signed [POS_FW-1:0] pos_full;
    logic signed [POS_W-1:0]  pos;
    logic signed [ERR_W-1:0]  err;

    assign o_ready   = !r_valid || i_ready;
    assign take      = i_valid && o_ready;
    assign idx       = JIDX_W'(i_item.joint);
    assign j_ok      = int'(i_item.joint) < JOINTS;
    assign is_sample = i_item.req_type == REQ_SAMPLE;
    assign produce   = j_ok && is_sample && r_primed[idx];

    always_comb begin
        diff  = $signed({1'b0, i_item.reading}) - $signed({1'b0, r_prior[idx]});
        adiff = diff[READ_W] ? (READ_W + 1)'(-diff) : (READ_W + 1)'(diff);
        wrap  = adiff > {1'b0, i_cfg.wrap_threshold};
        // A large backward jump means the reading passed zero going forward.
        if (!wrap) begin
            n_rev = r_rev[idx];
        end else if (diff[READ_W]) begin
            n_rev = r_rev[idx] + REV_W'(1);
        end else begin
            n_rev = r_rev[idx] - REV_W'(1);
        end
        pos_full = POS_FW'($signed(n_rev)) * CPR_POS
                 + $signed({{(POS_FW - READ_W){1'b0}}, i_item.reading});
        if (pos_full > POS_MAX_F) begin
            pos = POS_W'(POS_MAX_F);
        end else if (pos_full < POS_MIN_F) begin
            pos = POS_W'(POS_MIN_F);
        end else begin
            pos = POS_W'(pos_full);
        end
        err = ERR_W'(r_target[idx]) - ERR_W'(pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < JOINTS; i++) begin
                r_prior[i]  <= '0;
                r_primed[i] <= 1'b0;
                r_rev[i]    <= '0;
                r_target[i] <= '0;
            end
        end else if (take && j_ok) begin
            if (!is_sample) begin
                r_target[idx] <= i_item.target;
            end else begin
                r_primed[idx] <= 1'b1;
                r_prior[idx]  <= i_item.reading;
                if (r_primed[idx]) begin
                    r_rev[idx] <= n_rev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && produce) begin
            r_item.joint    <= i_item.joint;
            r_item.position <= pos;
            r_item.err      <= err;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    `MJSC_ASSERT_NEXT(a_target_no_result, i_clk, i_rst_n, take && !is_sample, !r_valid)
    `MJSC_ASSERT_NEXT(a_primes_joint, i_clk, i_rst_n, take && j_ok && is_sample, r_primed[$past(idx)])

endmodule

// ===== hw/rtl/mjsc_speed_calc.sv =====
// Speed command stages: deadband and saturation choice, gain product, reciprocal divide.
`include "multiturn_joint_speed_control_unit_macros.svh"

module mjsc_speed_calc import mjsc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_err_item i_item,
    output logic      o_ready,
    mjsc_res_if.source o_res
);

    typedef enum logic [1:0] {
        SPD_ZERO,
        SPD_PROP,
        SPD_SAT
    } t_spd_mode;

    typedef struct packed {
        logic [JOINT_W-1:0]      joint;
        logic signed [POS_W-1:0] position;
        logic                    neg;
        t_spd_mode               mode;
        logic [PROD_W-1:0]       prod;
    } t_gain_item;

    logic       r3_valid;
    t_gain_item r3;

    logic                    r_o_valid;
    logic [JOINT_W-1:0]      r_o_joint;
    logic signed [POS_W-1:0] r_o_pos;
    logic signed [SPD_W-1:0] r_o_spd;

    logic                         rdy_o;
    logic [ERR_W-1:0]             aerr;
    t_spd_mode                    mode;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W+RECIP_W-1:0]    qprod;
    logic [MAXS_W-1:0]            quot;
    logic [MAXS_W-1:0]            mag;
    logic signed [SPD_W-1:0]      spd;
    logic signed [SPD_W-1:0]      spd_lim;
    logic                         spd_in_range;

    assign rdy_o   = !r_o_valid || o_res.ready;
    assign o_ready = !r3_valid || rdy_o;

    always_comb begin
        aerr = i_item.err[ERR_W-1] ? ERR_W'(-i_item.err) : ERR_W'(i_item.err);
        priority if (aerr <= ERR_W'(i_cfg.deadband)) begin
            mode = SPD_ZERO;
        end else if (aerr >= ERR_W'(COUNTS_PER_REV)) begin
            mode = SPD_SAT;
        end else begin
            mode = SPD_PROP;
        end
        prod = PROD_W'(aerr[CPR_W-1:0]) * PROD_W'(i_cfg.speed_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (o_ready) begin
            r3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r3.joint    <= i_item.joint;
            r3.position <= i_item.position;
            r3.neg      <= i_item.err[ERR_W-1];
            r3.mode     <= mode;
            r3.prod     <= prod;
        end
    end

    always_comb begin
        qprod = (PROD_W + RECIP_W)'(r3.prod) * (PROD_W + RECIP_W)'(RECIP);
        quot  = qprod[RECIP_SHIFT +: MAXS_W];
        unique case (r3.mode)
            SPD_ZERO: mag = '0;
            SPD_PROP: mag = quot;
            SPD_SAT:  mag = i_cfg.speed_limit;
            default:  mag = '0;
        endcase
        spd = r3.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (rdy_o) begin
            r_o_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r3_valid && rdy_o) begin
            r_o_joint <= r3.joint;
            r_o_pos   <= r3.position;
            r_o_spd   <= spd;
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.joint_out = r_o_joint;
    assign o_res.position  = r_o_pos;
    assign o_res.speed_cmd = r_o_spd;

    assign spd_lim      = $signed({1'b0, i_cfg.speed_limit});
    assign spd_in_range = (r_o_spd <= spd_lim) && (r_o_spd >= -spd_lim);

    `MJSC_ASSERT_IMPL(a_speed_bound, i_clk, i_rst_n, r_o_valid, spd_in_range)
    `MJSC_ASSERT_NEXT(a_deadband_zero, i_clk, i_rst_n, r3_valid && rdy_o && (r3.mode == SPD_ZERO), r_o_spd == '0)

endmodule

// ===== hw/rtl/multiturn_joint_speed_control_unit.sv =====
// Top level of the multi-turn joint speed control block for three servo joints.
// A sample item passes the input, state, gain and output registers to give its result.
// Throughput: one item per cycle unless the output stalls; joint state is read and written
// back in the same cycle. Items that give no result (set-target, first sample of a joint,
// bad joint) leave the pipeline after the state stage. Reset is synchronous and active
// low: it empties the pipeline, clears all joint state at once and loads register defaults.
module multiturn_joint_speed_control_unit import mjsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mjsc_req_if.sink             i_req,
    mjsc_res_if.source           o_res
);

    // Configuration registers; writes to an index past the list are dropped.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wrap_threshold <= WRAP_THRESHOLD_RST;
            r_cfg.deadband       <= DEADBAND_RST;
            r_cfg.speed_limit    <= SPEED_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WRAP_THRESHOLD: r_cfg.wrap_threshold <= i_cfg_data[READ_W-1:0];
                CFG_DEADBAND:       r_cfg.deadband       <= i_cfg_data[READ_W-1:0];
                CFG_SPEED_LIMIT:    r_cfg.speed_limit    <= i_cfg_data[MAXS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register. It takes a new transfer whenever it is empty or its item moves on,
    // so a result waiting at the output stalls input only once every stage is full.
    logic r1_valid;
    t_req r1;
    logic st_ready;

    assign i_req.ready = !r1_valid || st_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r1.req_type <= i_req.req_type;
            r1.joint    <= i_req.joint;
            r1.reading  <= i_req.reading;
            r1.target   <= i_req.target;
        end
    end

    // The state stage unwraps the reading and forms position and error; the speed stages
    // pick deadband, proportional or saturated speed and hold the output register.
    logic      s2_valid;
    t_err_item s2;
    logic      sp_ready;

    mjsc_joint_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (r1_valid),
        .i_item  (r1),
        .o_ready (st_ready),
        .o_valid (s2_valid),
        .o_item  (s2),
        .i_ready (sp_ready)
    );

    mjsc_speed_calc u_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s2_valid),
        .i_item  (s2),
        .o_ready (sp_ready),
        .o_res   (o_res)
    );

endmodule

// ===== dv/multiturn_joint_speed_control_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the multi-turn joint speed control block.

localparam int SB_REPORT_CAP = 60;

// One expected result: the joint, its unwrapped position and its speed command.
typedef struct {
    logic [mjsc_pkg::JOINT_W-1:0]      joint;
    logic signed [mjsc_pkg::POS_W-1:0] position;
    logic signed [mjsc_pkg::SPD_W-1:0] speed_cmd;
} t_joint_cmd;

// Tracks per-joint revolutions and targets, predicts speed commands and checks the results.
class speed_cmd_scoreboard;
    logic [mjsc_pkg::READ_W-1:0]       wrap_threshold;
    logic [mjsc_pkg::READ_W-1:0]       deadband;
    logic [mjsc_pkg::MAXS_W-1:0]       speed_limit;
    logic [mjsc_pkg::READ_W-1:0]       last_reading [mjsc_pkg::JOINTS];
    bit                                primed       [mjsc_pkg::JOINTS];
    logic [mjsc_pkg::REV_W-1:0]        rev_count    [mjsc_pkg::JOINTS];
    logic signed [mjsc_pkg::TGT_W-1:0] target_pos   [mjsc_pkg::JOINTS];
    t_joint_cmd                        expected_cmds [$];
    int                                mismatches;
    int                                reports;

    function new();
        wrap_threshold = mjsc_pkg::WRAP_THRESHOLD_RST;
        deadband       = mjsc_pkg::DEADBAND_RST;
        speed_limit    = mjsc_pkg::SPEED_LIMIT_RST;
        for (int i = 0; i < mjsc_pkg::JOINTS; i++) begin
            last_reading[i] = '0;
            primed[i]       = 1'b0;
            rev_count[i]    = '0;
            target_pos[i]   = '0;
        end
        mismatches = 0;
        reports    = 0;
    endfunction

    function void write_reg(input logic [mjsc_pkg::CFG_IDX_W-1:0] idx,
                            input logic [mjsc_pkg::CFG_W-1:0] data);
        case (idx)
            mjsc_pkg::CFG_WRAP_THRESHOLD: wrap_threshold = data[mjsc_pkg::READ_W-1:0];
            mjsc_pkg::CFG_DEADBAND:       deadband       = data[mjsc_pkg::READ_W-1:0];
            mjsc_pkg::CFG_SPEED_LIMIT:    speed_limit    = data[mjsc_pkg::MAXS_W-1:0];
            default: ;
        endcase
    endfunction

    function longint position_of(input int j);
        return longint'($signed(rev_count[j])) * mjsc_pkg::COUNTS_PER_REV
               + longint'(last_reading[j]);
    endfunction

    function logic [mjsc_pkg::READ_W-1:0] last_reading_of(input int j);
        return last_reading[j];
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction

    // Updates the joint state for one accepted item and queues the result it causes.
    function void note_item(input mjsc_pkg::t_req item);
        longint     pos_hi = (longint'(1) <<< (mjsc_pkg::POS_W - 1)) - 1;
        longint     pos_lo = -(longint'(1) <<< (mjsc_pkg::POS_W - 1));
        longint     step, jump, pos, err, mag, cmd;
        t_joint_cmd want;
        int         j;
        if (item.joint >= mjsc_pkg::JOINTS)
            return;
        j = item.joint;
        if (item.req_type == mjsc_pkg::REQ_TARGET) begin
            target_pos[j] = item.target;
            return;
        end
        if (!primed[j]) begin
            primed[j]       = 1'b1;
            last_reading[j] = item.reading;
            return;
        end
        step = longint'(item.reading) - longint'(last_reading[j]);
        jump = (step < 0) ? -step : step;
        // A falling reading means the encoder passed its top going forward.
        if (jump > longint'(wrap_threshold)) begin
            if (step < 0)
                rev_count[j] = rev_count[j] + 1'b1;
            else
                rev_count[j] = rev_count[j] - 1'b1;
        end
        last_reading[j] = item.reading;
        pos = position_of(j);
        if (pos > pos_hi)
            pos = pos_hi;
        if (pos < pos_lo)
            pos = pos_lo;
        err = longint'(target_pos[j]) - pos;
        mag = (err < 0) ? -err : err;
        if (mag <= longint'(deadband))
            cmd = 0;
        else if (mag < mjsc_pkg::COUNTS_PER_REV)
            cmd = (err * longint'(speed_limit)) / mjsc_pkg::COUNTS_PER_REV;
        else
            cmd = (err > 0) ? longint'(speed_limit) : -longint'(speed_limit);
        want.joint     = item.joint;
        want.position  = pos[mjsc_pkg::POS_W-1:0];
        want.speed_cmd = cmd[mjsc_pkg::SPD_W-1:0];
        expected_cmds.push_back(want);
    endfunction

    function void report(input string msg);
        mismatches++;
        if (reports < SB_REPORT_CAP)
            $display("%s", msg);
        reports++;
    endfunction

    function void check_cmd(input logic [mjsc_pkg::JOINT_W-1:0] joint,
                            input logic signed [mjsc_pkg::POS_W-1:0] position,
                            input logic signed [mjsc_pkg::SPD_W-1:0] speed_cmd);
        t_joint_cmd want;
        if (expected_cmds.size() == 0) begin
            report($sformatf("%0t: unexpected result, expected none, got joint %0d pos %0d cmd %0d",
                             $time, joint, position, speed_cmd));
            return;
        end
        want = expected_cmds.pop_front();
        if (joint !== want.joint)
            report($sformatf("%0t: joint_out expected %0d, got %0d",
                             $time, want.joint, joint));
        if (position !== want.position)
            report($sformatf("%0t: position of joint %0d expected %0d, got %0d",
                             $time, want.joint, want.position, position));
        if (speed_cmd !== want.speed_cmd)
            report($sformatf("%0t: speed_cmd of joint %0d expected %0d, got %0d",
                             $time, want.joint, want.speed_cmd, speed_cmd));
    endfunction
endclass

module multiturn_joint_speed_control_unit_tb;
    import mjsc_pkg::*;

    // The limit leaves ample margin over a correct run, even with every gap and stall at
    // its longest.
    localparam int CYCLE_LIMIT      = 1_000_000;
    // Wait after the last result, so that trailing items without one leave the pipeline.
    localparam int DRAIN_CYCLES     = 8;
    // A short climb of single-count steps under a zero threshold.
    localparam int WRAP_SWEEP_ITEMS = 40;
    localparam int PHASE_ITEMS      = 157;
    localparam int RANDOM_PHASES    = 5;
    localparam int LONG_HOLD_CYCLES = 150;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    mjsc_req_if req_ch ();
    mjsc_res_if res_ch ();

    // Idling controls: the sender's gaps, the receiver's stalls and the one long hold.
    bit idle_on;
    bit stall_on;
    bit long_hold_req;

    int cycle_count = 0;

    speed_cmd_scoreboard cmd_sb = new();

    multiturn_joint_speed_control_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_res       (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // The cycle counter ends a run that hangs, for example on a result that never comes.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Idle lengths are mostly zero or short, with an occasional long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Fields that the request type leaves unused still carry random bits.
    function automatic t_req sample_req(input int j, input logic [READ_W-1:0] rd);
        t_req item;
        item.req_type = REQ_SAMPLE;
        item.joint    = JOINT_W'(j);
        item.reading  = rd;
        item.target   = TGT_W'($urandom);
        return item;
    endfunction

    function automatic t_req target_req(input int j, input logic signed [TGT_W-1:0] aim);
        t_req item;
        item.req_type = REQ_TARGET;
        item.joint    = JOINT_W'(j);
        item.reading  = READ_W'($urandom);
        item.target   = aim;
        return item;
    endfunction

    // The receiver samples each transfer at the clock edge and then picks its next ready.
    // A stall is counted down here; the single long hold lets the block fill up and
    // push back on the request channel while the sender keeps offering items.
    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                cmd_sb.check_cmd(res_ch.joint_out, res_ch.position, res_ch.speed_cmd);
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD_CYCLES;
            end else if (hold_left == 0 && stall_on && $urandom_range(0, 3) == 0) begin
                hold_left = idle_len();
            end
            res_ch.ready <= i_rst_n && (hold_left == 0);
            if (hold_left > 0)
                hold_left--;
        end
    end

    // Offers one item and returns at the edge of its transfer. Valid is lowered only
    // when a gap precedes the item, so it never falls and rises within one time step.
    task automatic send_item(input t_req item);
        int gap;
        gap = idle_on ? idle_len() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= item.req_type;
        req_ch.joint    <= item.joint;
        req_ch.reading  <= item.reading;
        req_ch.target   <= item.target;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        cmd_sb.note_item(item);
    endtask

    // Writes all three registers on back-to-back cycles. The threshold and deadband
    // words carry random upper bits, which the block must drop.
    task automatic set_config(input logic [READ_W-1:0] thr, input logic [READ_W-1:0] band,
                              input logic [MAXS_W-1:0] top_speed);
        logic [CFG_W-1:0] thr_word;
        logic [CFG_W-1:0] band_word;
        thr_word  = {3'($urandom), thr};
        band_word = {3'($urandom), band};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_WRAP_THRESHOLD;
        i_cfg_data  <= thr_word;
        @(posedge i_clk);
        cmd_sb.write_reg(CFG_WRAP_THRESHOLD, thr_word);
        i_cfg_index <= CFG_DEADBAND;
        i_cfg_data  <= band_word;
        @(posedge i_clk);
        cmd_sb.write_reg(CFG_DEADBAND, band_word);
        i_cfg_index <= CFG_SPEED_LIMIT;
        i_cfg_data  <= top_speed;
        @(posedge i_clk);
        cmd_sb.write_reg(CFG_SPEED_LIMIT, top_speed);
        i_cfg_we <= 1'b0;
    endtask

    // Stops offering, waits for every queued result, then lets trailing items that
    // cause no result leave the pipeline before the registers may change.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (cmd_sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random items are mostly well-formed: samples that move a little from the last
    // reading (crossing the top and bottom of the encoder range now and then) or jump
    // near the wrap threshold, and targets placed around the current position so that
    // the deadband, the proportional band and saturation are all reached. The rest are
    // full-range values and items for a joint that does not exist.
    task automatic random_item();
        t_req                item;
        int                  j;
        int                  pick;
        int                  off;
        int                  span;
        longint              aim;
        logic [READ_W-1:0]   base;
        pick = $urandom_range(0, 99);
        j    = $urandom_range(0, JOINTS - 1);
        item = sample_req(j, READ_W'($urandom));
        if (pick < 4) begin
            item.joint    = 2'd3;
            item.req_type = 1'($urandom);
        end else if (pick < 24) begin
            item.req_type = REQ_TARGET;
            aim = cmd_sb.position_of(j);
            case ($urandom_range(0, 9))
                0, 1, 2: off = int'($urandom_range(0, 2 * cmd_sb.deadband + 4))
                               - (int'(cmd_sb.deadband) + 2);
                3, 4, 5, 6: off = int'($urandom_range(0, 8400)) - 4200;
                7, 8: off = int'($urandom_range(0, 200_000)) - 100_000;
                default: off = 0;
            endcase
            if (off != 0 || $urandom_range(0, 9) != 0)
                item.target = TGT_W'(aim + off);
        end else begin
            base = cmd_sb.last_reading_of(j);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                    item.reading = base + READ_W'(int'($urandom_range(0, 600)) - 300);
                6, 7: begin
                    span = int'(cmd_sb.wrap_threshold) + int'($urandom_range(0, 6)) - 3;
                    item.reading = $urandom_range(0, 1) ? base + READ_W'(span)
                                                        : base - READ_W'(span);
                end
                8: ;
                default: item.reading = $urandom_range(0, 1) ? {READ_W{1'b1}} : '0;
            endcase
        end
        send_item(item);
    endtask

    initial begin : stimulus
        int                p;
        logic [READ_W-1:0] sweep_rd;

        // Every input is known from time zero, while reset is held low.
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_TARGET;
        req_ch.joint    <= '0;
        req_ch.reading  <= '0;
        req_ch.target   <= '0;
        i_cfg_we        <= 1'b0;
        i_cfg_index     <= CFG_WRAP_THRESHOLD;
        i_cfg_data      <= '0;
        i_rst_n         <= 1'b0;
        idle_on         = 1'b1;
        stall_on        <= 1'b1;
        long_hold_req   <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset register values (threshold 2000, deadband 11,
        // top speed 30000). The first sample of a joint only primes it.
        send_item(sample_req(0, 12'd0));
        // A full-range rise counts one revolution back; the position lands on zero.
        send_item(sample_req(0, 12'd4095));
        // Largest and smallest targets saturate the command in both directions.
        send_item(target_req(0, 28'sh7FFFFFF));
        send_item(sample_req(0, 12'd0));
        send_item(target_req(0, 28'sh8000000));
        // A jump of exactly the threshold is no wrap; one count more is.
        send_item(sample_req(0, 12'd2000));
        send_item(sample_req(0, 12'd4001));
        // Joint 1: just outside and at the deadband, truncation toward zero on both
        // signs, and the edges of the proportional band.
        send_item(target_req(1, 28'sd12));
        send_item(sample_req(1, 12'd0));
        send_item(sample_req(1, 12'd0));
        send_item(target_req(1, 28'sd11));
        send_item(sample_req(1, 12'd0));
        send_item(target_req(1, -28'sd100));
        send_item(sample_req(1, 12'd0));
        send_item(target_req(1, 28'sd4094));
        send_item(sample_req(1, 12'd0));
        send_item(target_req(1, -28'sd4095));
        send_item(sample_req(1, 12'd0));
        // A joint index past the last joint is dropped for both request types.
        send_item(target_req(3, 28'sd5));
        send_item(sample_req(3, 12'd4095));
        // Joint 2 primes at the top of the range and then falls to zero: one revolution on.
        send_item(sample_req(2, 12'd4095));
        send_item(sample_req(2, 12'd0));
        send_item(target_req(2, 28'sd4095));
        send_item(sample_req(2, 12'd1));
        wait_drained();

        // With a zero threshold every rising step counts a revolution back, so a short
        // climb moves joint 0's counter by one on every item, back to back.
        set_config(12'd0, 12'd25, 15'd32767);
        idle_on = 1'b0;
        stall_on <= 1'b0;
        sweep_rd = cmd_sb.last_reading_of(0);
        repeat (WRAP_SWEEP_ITEMS) begin
            sweep_rd = sweep_rd + 1'b1;
            send_item(sample_req(0, sweep_rd));
        end
        wait_drained();

        // Random phases under extreme, random and reset register settings, with the
        // idling of both sides switched on and off from phase to phase.
        for (p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_config(12'd0, 12'd0, 15'd32767);
                1: set_config(12'd4095, 12'd4095, 15'd0);
                4: set_config(WRAP_THRESHOLD_RST, DEADBAND_RST, SPEED_LIMIT_RST);
                default: set_config(12'($urandom), 12'($urandom_range(0, 300)), 15'($urandom));
            endcase
            idle_on = (p == 0 || p == 3);
            stall_on <= (p != 1);
            if (p == 2)
                long_hold_req <= 1'b1;
            repeat (PHASE_ITEMS) random_item();
            wait_drained();
        end

        if (cmd_sb.mismatches == 0 && cmd_sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mjsc_pkg.sv
hw/rtl/mjsc_req_if.sv
hw/rtl/mjsc_res_if.sv
hw/rtl/mjsc_joint_state.sv
hw/rtl/mjsc_speed_calc.sv
hw/rtl/multiturn_joint_speed_control_unit.sv
dv/multiturn_joint_speed_control_unit_tb.sv
